// ----- rtl/core/i2cmb_pkg.sv -----
// Shared types and constants for the I2C master byte engine.
`default_nettype none
package i2cmb_pkg;

	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_WRITE = 3'd2;
	localparam logic [2:0] CMD_READ  = 3'd3;
	localparam logic [2:0] CMD_STOP  = 3'd4;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_CHECK   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd1;

	localparam logic       ACK_CHECK_RESET   = 1'b1;
	localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd5;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] write_byte;
		logic       send_ack;
		logic       sda_in;
		logic       timeout_tick;
	} cmd_word_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive_enable;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_error;
	} res_word_t;

	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_START,
		CLS_WRITE,
		CLS_READ,
		CLS_STOP
	} cmd_class_t;

	typedef struct packed {
		cmd_class_t cls;
		logic [7:0] write_byte;
		logic       send_ack;
		logic       sda_in;
		logic       timeout_tick;
	} job_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START,
		PH_STOP,
		PH_W_DATA,
		PH_W_HIGH,
		PH_W_LOW,
		PH_W_REL,
		PH_W_ACKH,
		PH_W_WAIT,
		PH_W_ACKL,
		PH_R_REL,
		PH_R_HIGH,
		PH_R_LOW,
		PH_R_ACK
	} phase_t;

endpackage
`default_nettype wire

// ----- rtl/core/i2cmb_front.sv -----
// Front end: takes command words and classifies the command code.
`default_nettype none
module i2cmb_front (
	input  wire logic                cmd_valid,
	output logic                     cmd_ready,
	input  wire i2cmb_pkg::cmd_word_t cmd_word,
	output logic                     push_valid,
	input  wire logic                push_ready,
	output i2cmb_pkg::job_t          push_job
);
	import i2cmb_pkg::*;

	cmd_class_t cls;

	always_comb begin
		case (cmd_word.cmd)
			CMD_START: cls = CLS_START;
			CMD_WRITE: cls = CLS_WRITE;
			CMD_READ:  cls = CLS_READ;
			CMD_STOP:  cls = CLS_STOP;
			default:   cls = CLS_NONE;
		endcase
	end

	assign push_valid              = cmd_valid;
	assign cmd_ready               = push_ready;
	assign push_job.cls            = cls;
	assign push_job.write_byte     = cmd_word.write_byte;
	assign push_job.send_ack       = cmd_word.send_ack;
	assign push_job.sda_in         = cmd_word.sda_in;
	assign push_job.timeout_tick   = cmd_word.timeout_tick;

endmodule
`default_nettype wire

// ----- rtl/core/i2cmb_queue.sv -----
// Short job queue between the classifier and the bus sequencer.
`default_nettype none
module i2cmb_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire i2cmb_pkg::job_t push_job,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output i2cmb_pkg::job_t      pop_job
);
	import i2cmb_pkg::*;

	job_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != QUEUE_CW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CW'(QUEUE_DEPTH))
		else $error("queue count out of range");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == QUEUE_CW'(QUEUE_DEPTH) && !pop |=> count_q == QUEUE_CW'(QUEUE_DEPTH))
		else $error("queue lost an entry while full");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 || count_q == QUEUE_CW'(QUEUE_DEPTH) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

// ----- rtl/core/i2cmb_back.sv -----
// Back end: SCL/SDA phase sequencer, config registers and result register.
`default_nettype none
module i2cmb_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       job_valid,
	output logic                            job_ready,
	input  wire i2cmb_pkg::job_t            job,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output i2cmb_pkg::res_word_t            res_word,
	input  wire logic                       cfg_we,
	input  wire logic [i2cmb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [i2cmb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import i2cmb_pkg::*;

	logic       ack_check_q;
	logic [7:0] ack_timeout_q;

	phase_t     phase_q;
	logic [3:0] bc_q;
	logic [7:0] sh_q;
	logic [7:0] to_q;
	logic       ats_q;
	logic [7:0] rx_q;
	logic       err_q;
	logic       scl_q;
	logic       sda_q;
	logic       oe_q;

	phase_t     ph_e;
	logic [3:0] bc_e;
	logic [7:0] sh_e;
	logic       ats_e;
	logic       err_e;

	phase_t     ph_n;
	logic [3:0] bc_n;
	logic [3:0] bc_inc;
	logic [7:0] sh_n;
	logic [7:0] to_n;
	logic [7:0] to_inc;
	logic       to_hit;
	logic [7:0] rx_n;
	logic       err_n;
	logic       scl_n;
	logic       sda_n;
	logic       oe_n;
	logic       done;

	logic       advance;
	res_word_t  res_q;
	logic       res_valid_q;

	assign job_ready = !res_valid_q || res_ready;
	assign advance   = job_valid && job_ready;
	assign bc_inc    = bc_e + 4'd1;
	assign to_inc    = to_q + 8'd1;
	assign to_hit    = (to_inc >= ack_timeout_q);

	// command dispatch out of idle
	always_comb begin
		ph_e  = phase_q;
		bc_e  = bc_q;
		sh_e  = sh_q;
		ats_e = ats_q;
		err_e = err_q;
		if (phase_q == PH_IDLE) begin
			bc_e = '0;
			case (job.cls)
				CLS_START: ph_e = PH_START;
				CLS_WRITE: begin
					ph_e  = PH_W_DATA;
					sh_e  = job.write_byte;
					err_e = 1'b0;
				end
				CLS_READ: begin
					ph_e  = PH_R_REL;
					sh_e  = '0;
					ats_e = job.send_ack;
				end
				CLS_STOP:  ph_e = PH_STOP;
				default:   ph_e = PH_IDLE;
			endcase
		end
	end

	// pins, counters, data
	always_comb begin
		bc_n  = bc_e;
		sh_n  = sh_e;
		to_n  = to_q;
		rx_n  = rx_q;
		err_n = err_e;
		scl_n = scl_q;
		sda_n = sda_q;
		oe_n  = oe_q;
		done  = 1'b0;
		case (ph_e)
			PH_START: begin
				case (bc_e)
					4'd0: begin
						oe_n  = 1'b1;
						sda_n = 1'b1;
					end
					4'd1: scl_n = 1'b1;
					4'd2: sda_n = 1'b0;
					default: begin
						scl_n = 1'b0;
						done  = 1'b1;
					end
				endcase
				bc_n = bc_inc;
			end
			PH_STOP: begin
				case (bc_e)
					4'd0: scl_n = 1'b0;
					4'd1: begin
						oe_n  = 1'b1;
						sda_n = 1'b0;
					end
					4'd2: scl_n = 1'b1;
					default: begin
						sda_n = 1'b1;
						done  = 1'b1;
					end
				endcase
				bc_n = bc_inc;
			end
			PH_W_DATA: begin
				oe_n  = 1'b1;
				sda_n = sh_e[7];
			end
			PH_W_HIGH: scl_n = 1'b1;
			PH_W_LOW: begin
				scl_n = 1'b0;
				sh_n  = {sh_e[6:0], 1'b0};
				bc_n  = bc_inc;
			end
			PH_W_REL: begin
				sda_n = 1'b1;
				oe_n  = 1'b0;
			end
			PH_W_ACKH: begin
				scl_n = 1'b1;
				to_n  = '0;
			end
			PH_W_WAIT: begin
				if (job.sda_in && job.timeout_tick) begin
					to_n = to_inc;
					if (to_hit) begin
						err_n = 1'b1;
					end
				end
			end
			PH_W_ACKL: begin
				scl_n = 1'b0;
				oe_n  = 1'b1;
				done  = 1'b1;
			end
			PH_R_REL: begin
				sda_n = 1'b1;
				oe_n  = 1'b0;
			end
			PH_R_HIGH: begin
				scl_n = 1'b1;
				sh_n  = {sh_e[6:0], job.sda_in};
			end
			PH_R_LOW: begin
				scl_n = 1'b0;
				bc_n  = bc_inc;
				if (bc_inc >= BITS_PER_BYTE) begin
					rx_n = sh_e;
					bc_n = '0;
				end
			end
			PH_R_ACK: begin
				oe_n = 1'b1;
				if (ats_e) begin
					case (bc_e)
						4'd0: sda_n = 1'b0;
						4'd1: scl_n = 1'b1;
						4'd2: scl_n = 1'b0;
						default: begin
							sda_n = 1'b1;
							done  = 1'b1;
						end
					endcase
				end else if (bc_e == 4'd0) begin
					scl_n = 1'b1;
				end else begin
					scl_n = 1'b0;
					done  = 1'b1;
				end
				bc_n = bc_inc;
			end
			default: begin
			end
		endcase
		if (done) begin
			bc_n = '0;
		end
	end

	// next phase
	always_comb begin
		case (ph_e)
			PH_START:  ph_n = PH_START;
			PH_STOP:   ph_n = PH_STOP;
			PH_W_DATA: ph_n = PH_W_HIGH;
			PH_W_HIGH: ph_n = PH_W_LOW;
			PH_W_LOW:  ph_n = (bc_inc >= BITS_PER_BYTE) ? PH_W_REL : PH_W_DATA;
			PH_W_REL:  ph_n = PH_W_ACKH;
			PH_W_ACKH: ph_n = ack_check_q ? PH_W_WAIT : PH_W_ACKL;
			PH_W_WAIT: begin
				if (!job.sda_in || (job.timeout_tick && to_hit)) begin
					ph_n = PH_W_ACKL;
				end else begin
					ph_n = PH_W_WAIT;
				end
			end
			PH_W_ACKL: ph_n = PH_W_ACKL;
			PH_R_REL:  ph_n = PH_R_HIGH;
			PH_R_HIGH: ph_n = PH_R_LOW;
			PH_R_LOW:  ph_n = (bc_inc >= BITS_PER_BYTE) ? PH_R_ACK : PH_R_HIGH;
			PH_R_ACK:  ph_n = PH_R_ACK;
			default:   ph_n = PH_IDLE;
		endcase
		if (done) begin
			ph_n = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_check_q   <= ACK_CHECK_RESET;
			ack_timeout_q <= ACK_TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACK_CHECK:   ack_check_q   <= cfg_data[0];
				CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bc_q    <= '0;
			sh_q    <= '0;
			to_q    <= '0;
			ats_q   <= 1'b0;
			rx_q    <= '0;
			err_q   <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			oe_q    <= 1'b1;
		end else if (advance) begin
			phase_q <= ph_n;
			bc_q    <= bc_n;
			sh_q    <= sh_n;
			to_q    <= to_n;
			ats_q   <= ats_e;
			rx_q    <= rx_n;
			err_q   <= err_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			oe_q    <= oe_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.scl_level        <= scl_n;
			res_q.sda_level        <= sda_n;
			res_q.sda_drive_enable <= oe_n;
			res_q.busy_res         <= (ph_n != PH_IDLE);
			res_q.done_res         <= done;
			res_q.read_data        <= rx_n;
			res_q.ack_error        <= err_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.done_res |-> !res_q.busy_res)
		else $error("done reported with command still busy");

	a_wait_scl_high: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_W_WAIT |-> scl_q && !oe_q)
		else $error("ack wait without SCL high and SDA released");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> bc_q == '0)
		else $error("bit counter not cleared in idle");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= BITS_PER_BYTE)
		else $error("bit counter past one byte");

endmodule
`default_nettype wire

// ----- rtl/core/i2c_master_byte_engine_top.sv -----
// Top level of the I2C master byte engine.
// Each command word is one bus tick: the engine takes one word per clock while the output
// side is not stalled and returns one result word per command word, in order, carrying
// the SCL/SDA levels, SDA drive enable, busy/done flags, last read byte and ack error
// after that tick. Throughput is one word per cycle while res_ready is not held low, set
// by the registered phase update of the sequencer; a word passes through the two-entry
// job queue and then the result register before its result is presented, and a stall on
// the output side holds words in the queue. Commands that arrive while a command is in
// progress are ignored, as are codes 5 to 7. Config writes take effect on the next edge
// and are meant for when no words are outstanding.
`default_nettype none
module i2c_master_byte_engine_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cmd_valid,
	output logic                                  cmd_ready,
	input  wire i2cmb_pkg::cmd_word_t             cmd_word,
	output logic                                  res_valid,
	input  wire logic                             res_ready,
	output i2cmb_pkg::res_word_t                  res_word,
	input  wire logic                             cfg_we,
	input  wire logic [i2cmb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [i2cmb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import i2cmb_pkg::*;

	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic job_valid;
	logic job_ready;
	job_t job;

	i2cmb_front u_front (
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd_word   (cmd_word),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	i2cmb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (job_valid),
		.pop_ready  (job_ready),
		.pop_job    (job)
	);

	i2cmb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job        (job),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_word   (res_word),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

endmodule
`default_nettype wire
